// File: rtl/bba_pkg.sv
// package for the buddy block allocator: sizes, payload structs, status codes,
// controller/datapath command and status structs, address and size helpers
// no dependencies
`timescale 1ns / 1ps

package bba_pkg;

    localparam int MAX_ORDER     = 10;
    localparam int MIN_SIZE      = 4096;
    localparam int TABLE_ENTRIES = 64;

    localparam int ORD_W   = 4;
    localparam int OFF_W   = MAX_ORDER;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W  = 32;
    localparam int FREE_W  = 23;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_BASE_ADDR = PADDR_W'(0);
    localparam logic [FREE_W-1:0]  TOTAL_BYTES   = FREE_W'(MIN_SIZE << MAX_ORDER);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ORDER   = 2'd1,
        ST_NOMEM   = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        SC_ALLOC = 2'd0,
        SC_EMPTY = 2'd1,
        SC_FREE  = 2'd2,
        SC_BUDDY = 2'd3
    } t_scan;

    typedef struct packed {
        t_func             func;
        logic [ORD_W-1:0]  block_order;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] block_address;
        logic [FREE_W-1:0] bytes_available;
    } t_rsp;

    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic [OFF_W-1:0] offset;
        logic             taken;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic    load;
        logic    scan_go;
        t_scan   mode;
        logic    k_init;
        logic    k_next;
        logic    e_sel;
        logic    split_a;
        logic    split_b;
        logic    take;
        logic    untake;
        logic    merge;
        logic    set_st;
        t_status st;
        logic    deliver;
    } t_cmd;

    typedef struct packed {
        logic func_free;
        logic ord_bad;
        logic busy;
        logic hit;
        logic taken;
        logic k_found;
        logic k_last;
        logic need_split;
        logic can_merge;
        logic out_free;
    } t_sts;

    function automatic logic [FREE_W-1:0] size_of(input logic [ORD_W-1:0] ord);
        return FREE_W'(MIN_SIZE) << ord;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] base,
                                                  input logic [OFF_W-1:0]  off);
        return base + ADDR_W'(ADDR_W'(off) * ADDR_W'(MIN_SIZE));
    endfunction

endpackage

// File: rtl/bba_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/bba_ctrl.sv
// request sequencer: alloc search, split loop, free lookup and merge loop
// depends on bba_pkg
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bba_pkg::t_sts i_sts,
    output bba_pkg::t_cmd o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'h0001,
        S_START     = 15'h0002,
        S_ASCAN     = 15'h0004,
        S_PICK      = 15'h0008,
        S_SPLIT_CHK = 15'h0010,
        S_ESCAN     = 15'h0020,
        S_SPLIT_A   = 15'h0040,
        S_SPLIT_B   = 15'h0080,
        S_TAKE      = 15'h0100,
        S_FSCAN     = 15'h0200,
        S_MCHK      = 15'h0400,
        S_BSCAN     = 15'h0800,
        S_MERGE     = 15'h1000,
        S_DONE      = 15'h2000,
        S_SPARE     = 15'h4000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mode = bba_pkg::SC_ALLOC;
        o_cmd.st   = bba_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.func_free) begin
                    o_cmd.scan_go = 1'b1;
                    o_cmd.mode    = bba_pkg::SC_FREE;
                    n_state       = S_FSCAN;
                end else if (i_sts.ord_bad) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = bba_pkg::ST_ORDER;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.scan_go = 1'b1;
                    o_cmd.mode    = bba_pkg::SC_ALLOC;
                    n_state       = S_ASCAN;
                end
            end
            S_ASCAN: begin
                if (!i_sts.busy) begin
                    o_cmd.k_init = 1'b1;
                    n_state      = S_PICK;
                end
            end
            S_PICK: begin
                // walk up the orders until one has a free block
                if (i_sts.k_found) begin
                    o_cmd.e_sel = 1'b1;
                    n_state     = S_SPLIT_CHK;
                end else if (i_sts.k_last) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = bba_pkg::ST_NOMEM;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.k_next = 1'b1;
                end
            end
            S_SPLIT_CHK: begin
                if (i_sts.need_split) begin
                    o_cmd.scan_go = 1'b1;
                    o_cmd.mode    = bba_pkg::SC_EMPTY;
                    n_state       = S_ESCAN;
                end else begin
                    n_state = S_TAKE;
                end
            end
            S_ESCAN: begin
                if (!i_sts.busy) begin
                    if (i_sts.hit) begin
                        n_state = S_SPLIT_A;
                    end else begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = bba_pkg::ST_NOMEM;
                        n_state      = S_DONE;
                    end
                end
            end
            S_SPLIT_A: begin
                o_cmd.split_a = 1'b1;
                n_state       = S_SPLIT_B;
            end
            S_SPLIT_B: begin
                o_cmd.split_b = 1'b1;
                n_state       = S_SPLIT_CHK;
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_state    = S_DONE;
            end
            S_FSCAN: begin
                if (!i_sts.busy) begin
                    if (i_sts.hit && i_sts.taken) begin
                        o_cmd.untake = 1'b1;
                        n_state      = S_MCHK;
                    end else begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = bba_pkg::ST_UNKNOWN;
                        n_state      = S_DONE;
                    end
                end
            end
            S_MCHK: begin
                if (i_sts.can_merge) begin
                    o_cmd.scan_go = 1'b1;
                    o_cmd.mode    = bba_pkg::SC_BUDDY;
                    n_state       = S_BSCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BSCAN: begin
                if (!i_sts.busy) begin
                    n_state = i_sts.hit ? S_MERGE : S_DONE;
                end
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = S_MCHK;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.deliver = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/bba_dp.sv
// datapath: block table (ram plus valid flops), table scan engine,
// per-order search results, split/merge updates, free byte count, result beat
// depends on bba_pkg and bba_ram
`timescale 1ns / 1ps

module bba_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bba_pkg::t_req                i_in_data,
    input  logic [bba_pkg::ADDR_W-1:0]   i_base,
    input  bba_pkg::t_cmd                i_cmd,
    output bba_pkg::t_sts                o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output bba_pkg::t_rsp                o_out_data
);

    localparam int IW = bba_pkg::IDX_W;
    localparam int OW = bba_pkg::OFF_W;
    localparam int KW = bba_pkg::ORD_W;
    localparam bba_pkg::t_entry ENTRY0_RST = '{
        order:  KW'(bba_pkg::MAX_ORDER),
        offset: '0,
        taken:  1'b0
    };

    // request
    bba_pkg::t_func               r_func;
    logic [KW-1:0]                r_ord;
    logic [bba_pkg::ADDR_W-1:0]   r_faddr;
    bba_pkg::t_status             r_st;
    logic [bba_pkg::ADDR_W-1:0]   r_addr;
    logic [bba_pkg::FREE_W-1:0]   r_free;

    // table
    logic [bba_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic                              r_e0_fresh;
    logic                              ram_we;
    logic [IW-1:0]                     ram_waddr;
    bba_pkg::t_entry                   ram_wdata;
    logic [bba_pkg::ENTRY_W-1:0]       ram_rdata;

    // scan engine
    logic          r_sc_run, r_sc_pend;
    logic [IW-1:0] r_sc_idx, r_sc_pidx;
    bba_pkg::t_scan r_mode;
    logic          r_hit;
    bba_pkg::t_entry ent;
    logic          ent_v;

    // working block
    logic [IW-1:0] r_e, r_b, r_slot;
    logic [KW-1:0] r_cur, r_k;
    logic [OW-1:0] r_off;
    logic          r_tk;

    logic          r_fnd  [0:bba_pkg::MAX_ORDER];
    logic [IW-1:0] r_fidx [0:bba_pkg::MAX_ORDER];
    logic [OW-1:0] r_foff [0:bba_pkg::MAX_ORDER];

    logic [OW-1:0] bmask, boff, min_off;
    logic          lower_is_b;
    logic [IW-1:0] lower_idx, higher_idx;

    logic          r_out_valid;
    bba_pkg::t_rsp r_out_data;

    bba_ram #(
        .WIDTH (bba_pkg::ENTRY_W),
        .DEPTH (bba_pkg::TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_sc_idx),
        .o_rdata (ram_rdata)
    );

    // entry 0 reads as the full region until first written
    assign ent   = (r_sc_pidx == '0 && r_e0_fresh) ? ENTRY0_RST
                                                   : bba_pkg::t_entry'(ram_rdata);
    assign ent_v = r_valid[r_sc_pidx];

    assign bmask      = OW'(1) << r_cur;
    assign boff       = r_off ^ bmask;
    assign min_off    = r_off & ~bmask;
    assign lower_is_b = (boff < r_off);
    assign lower_idx  = lower_is_b ? r_b : r_e;
    assign higher_idx = lower_is_b ? r_e : r_b;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_e;
        ram_wdata = '{order: r_cur, offset: r_off, taken: 1'b0};
        if (i_cmd.split_a) begin
            ram_we          = 1'b1;
            ram_wdata.order = r_cur - KW'(1);
        end else if (i_cmd.split_b) begin
            ram_we           = 1'b1;
            ram_waddr        = r_slot;
            ram_wdata.offset = r_off + bmask;
        end else if (i_cmd.take) begin
            ram_we          = 1'b1;
            ram_wdata.taken = 1'b1;
        end else if (i_cmd.untake) begin
            ram_we = 1'b1;
        end else if (i_cmd.merge) begin
            ram_we           = 1'b1;
            ram_waddr        = lower_idx;
            ram_wdata.order  = r_cur + KW'(1);
            ram_wdata.offset = min_off;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= bba_pkg::TABLE_ENTRIES'(1);
            r_e0_fresh  <= 1'b1;
            r_free      <= bba_pkg::TOTAL_BYTES;
            r_sc_run    <= 1'b0;
            r_sc_pend   <= 1'b0;
            r_sc_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sc_pend <= r_sc_run;
            if (i_cmd.scan_go) begin
                r_sc_run <= 1'b1;
                r_sc_idx <= '0;
            end else if (r_sc_run) begin
                r_sc_idx <= r_sc_idx + IW'(1);
                if (r_sc_idx == IW'(bba_pkg::TABLE_ENTRIES - 1)) begin
                    r_sc_run <= 1'b0;
                end
            end
            if ((ram_we && ram_waddr == '0) || (i_cmd.merge && higher_idx == '0)) begin
                r_e0_fresh <= 1'b0;
            end
            if (i_cmd.split_b) begin
                r_valid[r_slot] <= 1'b1;
            end
            if (i_cmd.merge) begin
                r_valid[higher_idx] <= 1'b0;
            end
            if (i_cmd.take) begin
                r_free <= r_free - bba_pkg::size_of(r_ord);
            end else if (i_cmd.untake) begin
                r_free <= r_free + bba_pkg::size_of(r_cur);
            end
            if (i_cmd.deliver) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and search results
    always_ff @(posedge i_clk) begin
        r_sc_pidx <= r_sc_idx;
        if (i_cmd.load) begin
            r_func  <= i_in_data.func;
            r_ord   <= i_in_data.block_order;
            r_faddr <= i_in_data.free_address;
            r_st    <= bba_pkg::ST_OK;
            r_addr  <= '0;
        end
        if (i_cmd.set_st) begin
            r_st <= i_cmd.st;
        end
        if (i_cmd.take) begin
            r_addr <= bba_pkg::addr_of(i_base, r_off);
        end
        if (i_cmd.scan_go) begin
            r_mode <= i_cmd.mode;
            r_hit  <= 1'b0;
            for (int k = 0; k <= bba_pkg::MAX_ORDER; k++) begin
                r_fnd[k] <= 1'b0;
            end
        end else if (r_sc_pend) begin
            case (r_mode)
                bba_pkg::SC_ALLOC: begin
                    if (ent_v && !ent.taken && ent.order <= KW'(bba_pkg::MAX_ORDER)
                        && !r_fnd[ent.order]) begin
                        r_fnd[ent.order]  <= 1'b1;
                        r_fidx[ent.order] <= r_sc_pidx;
                        r_foff[ent.order] <= ent.offset;
                    end
                end
                bba_pkg::SC_EMPTY: begin
                    if (!ent_v && !r_hit) begin
                        r_hit  <= 1'b1;
                        r_slot <= r_sc_pidx;
                    end
                end
                bba_pkg::SC_FREE: begin
                    if (ent_v && !r_hit && bba_pkg::addr_of(i_base, ent.offset) == r_faddr) begin
                        r_hit <= 1'b1;
                        r_e   <= r_sc_pidx;
                        r_cur <= ent.order;
                        r_off <= ent.offset;
                        r_tk  <= ent.taken;
                    end
                end
                bba_pkg::SC_BUDDY: begin
                    if (ent_v && !r_hit && r_sc_pidx != r_e && !ent.taken
                        && ent.order == r_cur && ent.offset == boff) begin
                        r_hit <= 1'b1;
                        r_b   <= r_sc_pidx;
                    end
                end
                default: begin
                    r_hit <= r_hit;
                end
            endcase
        end
        if (i_cmd.k_init) begin
            r_k <= r_ord;
        end else if (i_cmd.k_next) begin
            r_k <= r_k + KW'(1);
        end
        if (i_cmd.e_sel) begin
            r_e   <= r_fidx[r_k];
            r_off <= r_foff[r_k];
            r_cur <= r_k;
        end
        if (i_cmd.split_a) begin
            r_cur <= r_cur - KW'(1);
        end
        if (i_cmd.merge) begin
            r_e   <= lower_idx;
            r_off <= min_off;
            r_cur <= r_cur + KW'(1);
        end
        if (i_cmd.deliver) begin
            r_out_data.status          <= r_st;
            r_out_data.block_address   <= r_addr;
            r_out_data.bytes_available <= r_free;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.func_free  = (r_func == bba_pkg::FN_FREE);
        o_sts.ord_bad    = (r_ord > KW'(bba_pkg::MAX_ORDER));
        o_sts.busy       = r_sc_run || r_sc_pend;
        o_sts.hit        = r_hit;
        o_sts.taken      = r_tk;
        o_sts.k_found    = r_fnd[r_k];
        o_sts.k_last     = (r_k == KW'(bba_pkg::MAX_ORDER));
        o_sts.need_split = (r_cur > r_ord);
        o_sts.can_merge  = (r_cur < KW'(bba_pkg::MAX_ORDER));
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/buddy_block_allocator.sv
// buddy block allocator top level: apb base register, sequencer and datapath
// depends on bba_pkg, bba_ctrl, bba_dp
`timescale 1ns / 1ps

// Manages 2^MAX_ORDER blocks of MIN_SIZE bytes starting at base_address (apb
// byte address 0), tracked in a 64-entry block table held in a ram plus valid
// flops. One request is worked at a time; every table search is a full pass
// through the single ram read port. An allocate takes one pass, then picks an
// order, then one pass plus two writes per split, with up to ten splits. A free
// takes one pass to look up the address and one pass plus a write per buddy
// merge. The next request is taken while the previous result beat still waits
// at the output. No clearing pass is needed after reset.
module buddy_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bba_pkg::t_req                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bba_pkg::t_rsp                 o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]   paddr,
    input  logic [bba_pkg::PDATA_W-1:0]   pwdata,
    output logic [bba_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [bba_pkg::ADDR_W-1:0] r_base;
    bba_pkg::t_cmd cmd;
    bba_pkg::t_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (psel && penable && pwrite && paddr == bba_pkg::REG_BASE_ADDR) begin
            r_base <= pwdata;
        end
    end

    assign prdata = (paddr == bba_pkg::REG_BASE_ADDR) ? r_base : '0;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bba_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_base      (r_base),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // a failed request, allocate or free, reports a zero address
    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != bba_pkg::ST_OK) |->
            (o_out_data.block_address == '0))
        else $error("nonzero address on a failed request");

    // free count never exceeds the region
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.bytes_available <= bba_pkg::TOTAL_BYTES))
        else $error("bytes available beyond region size");

    // a taken request blocks the input on the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in work");

endmodule

// File: sim/tb_buddy_block_allocator.sv
// testbench for the buddy block allocator: directed and random alloc/free beats,
// apb base register writes, model-based result checking
// depends on bba_pkg and buddy_block_allocator
`timescale 1ns / 1ps

module tb_buddy_block_allocator;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    bba_pkg::t_req i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    bba_pkg::t_rsp o_out_data;
    logic psel, penable, pwrite;
    logic [bba_pkg::PADDR_W-1:0] paddr;
    logic [bba_pkg::PDATA_W-1:0] pwdata;
    logic [bba_pkg::PDATA_W-1:0] prdata;
    logic pready;

    buddy_block_allocator DUT (.*);

    // predictor copy of the block table
    logic                      tbl_valid [bba_pkg::TABLE_ENTRIES];
    logic [bba_pkg::ORD_W-1:0] tbl_order [bba_pkg::TABLE_ENTRIES];
    logic [bba_pkg::OFF_W-1:0] tbl_off   [bba_pkg::TABLE_ENTRIES];
    logic                      tbl_taken [bba_pkg::TABLE_ENTRIES];
    logic [31:0]               avail_bytes;
    logic [31:0]               region_base;

    bba_pkg::t_rsp rsp_queue[$];
    logic [31:0]   live_addrs[$];
    int            mismatches;
    int            idle_cycles;
    bit            stall_hold;
    bit            no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] block_addr(input logic [bba_pkg::OFF_W-1:0] off);
        return region_base + {off, 12'd0};
    endfunction

    function automatic int first_free_of(input int ord);
        for (int i = 0; i < bba_pkg::TABLE_ENTRIES; i++)
            if (tbl_valid[i] && !tbl_taken[i] && tbl_order[i] == ord) return i;
        return -1;
    endfunction

    function automatic int first_hole();
        for (int i = 0; i < bba_pkg::TABLE_ENTRIES; i++)
            if (!tbl_valid[i]) return i;
        return -1;
    endfunction

    task automatic table_reset();
        for (int i = 0; i < bba_pkg::TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0; tbl_order[i] = '0; tbl_off[i] = '0; tbl_taken[i] = 1'b0;
        end
        tbl_valid[0] = 1'b1;
        tbl_order[0] = bba_pkg::ORD_W'(bba_pkg::MAX_ORDER);
        avail_bytes  = bba_pkg::MIN_SIZE << bba_pkg::MAX_ORDER;
        region_base  = '0;
    endtask

    function automatic bba_pkg::t_rsp predict_request(input bba_pkg::t_req rq);
        bba_pkg::t_rsp r;
        int e, s, b, t;
        logic [bba_pkg::OFF_W-1:0] boff;
        r = '0;
        r.status = bba_pkg::ST_OK;
        e = -1;
        if (rq.func == bba_pkg::FN_ALLOC) begin
            if (rq.block_order > bba_pkg::MAX_ORDER) begin
                r.status = bba_pkg::ST_ORDER;
            end else begin
                for (int k = rq.block_order; k <= bba_pkg::MAX_ORDER && e < 0; k++)
                    e = first_free_of(k);
                if (e < 0) r.status = bba_pkg::ST_NOMEM;
                while (e >= 0 && tbl_order[e] > rq.block_order) begin
                    s = first_hole();
                    if (s < 0) begin
                        r.status = bba_pkg::ST_NOMEM;
                        e = -1;
                    end else begin
                        tbl_order[e] = tbl_order[e] - bba_pkg::ORD_W'(1);
                        tbl_valid[s] = 1'b1;
                        tbl_order[s] = tbl_order[e];
                        tbl_off[s]   = tbl_off[e] + (bba_pkg::OFF_W'(1) << tbl_order[e]);
                        tbl_taken[s] = 1'b0;
                    end
                end
                if (e >= 0) begin
                    tbl_taken[e] = 1'b1;
                    avail_bytes  = avail_bytes - (bba_pkg::MIN_SIZE << rq.block_order);
                    r.block_address = block_addr(tbl_off[e]);
                end
            end
        end else begin
            for (int i = 0; i < bba_pkg::TABLE_ENTRIES && e < 0; i++)
                if (tbl_valid[i] && block_addr(tbl_off[i]) == rq.free_address) e = i;
            if (e < 0 || !tbl_taken[e]) begin
                r.status = bba_pkg::ST_UNKNOWN;
            end else begin
                tbl_taken[e] = 1'b0;
                avail_bytes  = avail_bytes + (bba_pkg::MIN_SIZE << tbl_order[e]);
                b = 0;
                while (tbl_order[e] < bba_pkg::MAX_ORDER && b >= 0) begin
                    boff = tbl_off[e] ^ (bba_pkg::OFF_W'(1) << tbl_order[e]);
                    b = -1;
                    for (int i = 0; i < bba_pkg::TABLE_ENTRIES && b < 0; i++)
                        if (i != e && tbl_valid[i] && !tbl_taken[i] &&
                            tbl_order[i] == tbl_order[e] && tbl_off[i] == boff) b = i;
                    if (b >= 0) begin
                        if (tbl_off[b] < tbl_off[e]) begin
                            t = e; e = b; b = t;
                        end
                        tbl_order[e] = tbl_order[e] + bba_pkg::ORD_W'(1);
                        tbl_valid[b] = 1'b0; tbl_order[b] = '0;
                        tbl_off[b] = '0; tbl_taken[b] = 1'b0;
                    end
                end
            end
        end
        r.bytes_available = avail_bytes[bba_pkg::FREE_W-1:0];
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        bba_pkg::t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rsp_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", o_out_data);
            end else begin
                want = rsp_queue.pop_front();
                if (want.status != o_out_data.status ||
                    want.block_address != o_out_data.block_address ||
                    want.bytes_available != o_out_data.bytes_available) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d addr=%h avail=%0d got st=%0d addr=%h avail=%0d",
                                 want.status, want.block_address, want.bytes_available,
                                 o_out_data.status, o_out_data.block_address,
                                 o_out_data.bytes_available);
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n || stall_hold) i_out_stall <= stall_hold;
        else if (no_gaps) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 3) == 0);
    end

    // watchdog on cycles with no accepted beat and no apb select
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(input bba_pkg::t_func fn, input logic [3:0] ord,
                                input logic [31:0] fa);
        bba_pkg::t_req rq;
        rq.func = fn; rq.block_order = ord; rq.free_address = fa;
        i_in_data  <= rq;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        rsp_queue.push_back(predict_request(rq));
        if (fn == bba_pkg::FN_ALLOC && rsp_queue[$].status == bba_pkg::ST_OK)
            live_addrs.push_back(rsp_queue[$].block_address);
        @(negedge i_clk);
        if (!no_gaps && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (rsp_queue.size() != 0) @(negedge i_clk);
        repeat (800) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] val);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= bba_pkg::REG_BASE_ADDR;
        pwdata <= val; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        region_base = val;
    endtask

    task automatic free_random_live();
        int j;
        logic [31:0] a;
        j = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[j];
        live_addrs.delete(j);
        send_request(bba_pkg::FN_FREE, 4'd0, a);
    endtask

    task automatic test_directed();
        send_request(bba_pkg::FN_ALLOC, 4'd11, 0);
        send_request(bba_pkg::FN_ALLOC, 4'd15, 0);
        send_request(bba_pkg::FN_ALLOC, 4'd10, 0);
        send_request(bba_pkg::FN_ALLOC, 4'd0, 0);
        send_request(bba_pkg::FN_FREE, 4'd0, 32'hFFFF_FFFF);
        free_random_live();
        send_request(bba_pkg::FN_ALLOC, 4'd0, 0);
        send_request(bba_pkg::FN_ALLOC, 4'd0, 0);
        send_request(bba_pkg::FN_ALLOC, 4'd3, 0);
        send_request(bba_pkg::FN_FREE, 4'd0, region_base);
        send_request(bba_pkg::FN_FREE, 4'd0, region_base);
        send_request(bba_pkg::FN_FREE, 4'd0, region_base + 32'h1000);
        while (live_addrs.size() != 0) free_random_live();
    endtask

    // many order-0 allocs fill the table and hit the split failure
    task automatic test_table_full();
        for (int i = 0; i < 80; i++) send_request(bba_pkg::FN_ALLOC, 4'd0, 0);
        send_request(bba_pkg::FN_ALLOC, 4'd9, 0);
        while (live_addrs.size() != 0) free_random_live();
    endtask

    task automatic test_random(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) send_request(bba_pkg::FN_ALLOC, 4'($urandom_range(0, 6) == 0 ?
                                     $urandom_range(0, 15) : $urandom_range(0, 4)), 0);
            else if (r < 90 && live_addrs.size() != 0) free_random_live();
            else if (r < 95) send_request(bba_pkg::FN_FREE, 4'($urandom), $urandom);
            else send_request(bba_pkg::FN_FREE, 4'($urandom),
                              region_base + ($urandom_range(0, 1023) << 12));
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        stall_hold = 1;
        no_gaps = 1;
        fork
            begin
                for (int i = 0; i < 6; i++) send_request(bba_pkg::FN_ALLOC, 4'd0, 0);
            end
            begin
                repeat (3000) @(negedge i_clk);
                stall_hold = 0;
            end
        join
        no_gaps = 0;
        while (live_addrs.size() != 0) free_random_live();
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_data = '0; i_out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; idle_cycles = 0; stall_hold = 0; no_gaps = 0;
        table_reset();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_table_full();
        write_base(32'hFFFF_F000);
        test_directed();
        test_random(400);
        test_backpressure();
        write_base($urandom);
        no_gaps = 1;
        test_random(300);
        no_gaps = 0;
        write_base(32'h0000_0000);
        test_random(450);
        drain();
        if (mismatches == 0 && rsp_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_ctrl.sv
rtl/bba_dp.sv
rtl/buddy_block_allocator.sv
sim/tb_buddy_block_allocator.sv
